>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression never true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

>>> rtl/core/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg
// constants and step codes of the power meter post-processing block
// ----------------------------------------------------------------------------
package pmp_pkg;

    localparam int RAW_WIDTH_DEF = 24;

    localparam int MUL_W  = 48;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 78;
    localparam int DEN_W  = 48;
    localparam int CNT_W  = 7;
    localparam int VAL_W  = 48;
    localparam int PF_W   = 16;
    localparam int FREQ_W = 35;
    localparam int EN_W   = 64;
    localparam int GAIN_W = 32;
    localparam int PPK_W  = 20;
    localparam int ADDR_W = 5;
    localparam int STEP_W = 5;

    localparam logic [DEN_W-1:0]  MS_PER_HOUR  = 48'd3600000;
    localparam logic [FREQ_W-1:0] FREQ_NUM     = 35'd32768000000;
    localparam logic [15:0]       GAP_LIMIT    = 16'd10000;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'h0100_0000;
    localparam logic [PPK_W-1:0]  PPK_RESET    = 20'd3200;

    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [2:0] REG_VGAIN  = 3'd0;
    localparam logic [2:0] REG_IGAIN1 = 3'd1;
    localparam logic [2:0] REG_IGAIN2 = 3'd2;
    localparam logic [2:0] REG_PGAIN1 = 3'd3;
    localparam logic [2:0] REG_PGAIN2 = 3'd4;
    localparam logic [2:0] REG_QGAIN1 = 3'd5;
    localparam logic [2:0] REG_QGAIN2 = 3'd6;
    localparam logic [2:0] REG_PPK    = 3'd7;

    localparam logic [STEP_W-1:0] STEP_V   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_I1  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_I2  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_P1  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_P2  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_Q1  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_Q2  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_S1  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_S2  = 5'd8;
    localparam logic [STEP_W-1:0] STEP_XA  = 5'd9;
    localparam logic [STEP_W-1:0] STEP_IA  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_XR  = 5'd11;
    localparam logic [STEP_W-1:0] STEP_IR  = 5'd12;
    localparam logic [STEP_W-1:0] STEP_PF1 = 5'd13;
    localparam logic [STEP_W-1:0] STEP_PF2 = 5'd14;
    localparam logic [STEP_W-1:0] STEP_FR  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_EA  = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ER  = 5'd17;

endpackage

>>> rtl/core/power_meter_postprocess.sv
// ----------------------------------------------------------------------------
// power_meter_postprocess
// scales one set of raw metering registers into two channel results using a
// shared bit-serial multiplier and a bit-serial restoring divider
// ----------------------------------------------------------------------------
// an accepted reading runs through 11 multiply steps and 7 divide steps, one bit per cycle;
// each step loads its operands, iterates and writes back its result
// a new reading is taken only in idle, after both result words of the last one are taken
// a clear command clears the energies, gives no result word and leaves the block idle
// reset: synchronous active low, gains to 1.0, pulse constant to 3200, energies cleared
`include "assert_macros.svh"

module power_meter_postprocess #(
    parameter int RAW_WIDTH = pmp_pkg::RAW_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // voltage_raw, current_raw_one, current_raw_two, active_raw_one, active_raw_two,
    // reactive_raw_one, reactive_raw_two, frequency_raw, active_pulses,
    // reactive_pulses, elapsed_ms
    input  logic [((7*RAW_WIDTH+80+7)/8)*8-1:0] s_tdata,
    input  logic                        s_tuser,   // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // voltage, current, active_power, reactive_power, apparent_power,
    // power_factor, frequency, active_energy, reactive_energy
    output logic [423:0]                m_tdata,
    output logic                        m_tuser,   // channel
    output logic                        m_tlast
);

    localparam int IN_W   = ((7*RAW_WIDTH+80+7)/8)*8;
    localparam int O_I1   = RAW_WIDTH;
    localparam int O_I2   = 2*RAW_WIDTH;
    localparam int O_P1   = 3*RAW_WIDTH;
    localparam int O_P2   = 4*RAW_WIDTH;
    localparam int O_Q1   = 5*RAW_WIDTH;
    localparam int O_Q2   = 6*RAW_WIDTH;
    localparam int O_FR   = 7*RAW_WIDTH;
    localparam int O_AP   = 7*RAW_WIDTH+16;
    localparam int O_RP   = 7*RAW_WIDTH+40;
    localparam int O_DT   = 7*RAW_WIDTH+64;
    localparam int MW     = pmp_pkg::MUL_W;
    localparam int PW     = pmp_pkg::PROD_W;
    localparam int NW     = pmp_pkg::NUM_W;
    localparam int DW     = pmp_pkg::DEN_W;
    localparam int VW     = pmp_pkg::VAL_W;
    localparam int EW     = pmp_pkg::EN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_ITER = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_OUT0 = 3'd4;
    localparam logic [2:0] ST_OUT1 = 3'd5;

    logic [2:0]                     state_reg;
    logic [pmp_pkg::STEP_W-1:0]     step_reg;
    logic [pmp_pkg::CNT_W-1:0]      cnt_reg;
    logic [31:0]                    vgain_reg, igain1_reg, igain2_reg;
    logic [31:0]                    pgain1_reg, pgain2_reg, qgain1_reg, qgain2_reg;
    logic [pmp_pkg::PPK_W-1:0]      ppk_reg;
    logic [EW-1:0]                  ea1_reg, er1_reg, ea2_reg, er2_reg;
    logic                           have_prev_reg;

    logic [IN_W-1:0]                in_data_reg;
    logic [PW-1:0]                  prod_reg, prod_next;
    logic [MW-1:0]                  mul_a_reg;
    logic [NW-1:0]                  num_reg;
    logic [DW-1:0]                  den_reg, rem_reg, rem_next;
    logic [VW-1:0]                  v_reg, i1_reg, i2_reg, p1_reg, p2_reg, q1_reg, q2_reg;
    logic [VW-1:0]                  s1_reg, s2_reg;
    logic [pmp_pkg::PF_W-1:0]       pf1_reg, pf2_reg;
    logic [pmp_pkg::FREQ_W-1:0]     f_reg;
    logic [EW-1:0]                  inca_reg, incr_reg;

    logic [MW-1:0]                  mul_a, mul_b;
    logic [NW-1:0]                  div_num;
    logic [DW-1:0]                  div_den;
    logic                           is_div, last_iter, qbit;
    logic [DW:0]                    trial;
    logic [MW:0]                    mul_sum;
    logic [VW-1:0]                  sat8, sat16;
    logic [pmp_pkg::PF_W-1:0]       pf_q;
    logic                           in_acc, cfg_wr, ch;
    logic [15:0]                    fr_raw, dt_raw;

    function automatic logic [MW-1:0] ext_raw(input logic [RAW_WIDTH-1:0] r);
        ext_raw = {{(MW-RAW_WIDTH){1'b0}}, r};
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic [RAW_WIDTH-1:0] r);
        logic [RAW_WIDTH-1:0] m;
        m = r[RAW_WIDTH-1] ? RAW_WIDTH'(~r + 1'b1) : r;
        mag_of = ext_raw(m);
    endfunction

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign fr_raw   = in_data_reg[O_FR +: 16];
    assign dt_raw   = in_data_reg[O_DT +: 16];

    always_comb begin
        case (paddr[4:2])
            pmp_pkg::REG_VGAIN:  prdata = vgain_reg;
            pmp_pkg::REG_IGAIN1: prdata = igain1_reg;
            pmp_pkg::REG_IGAIN2: prdata = igain2_reg;
            pmp_pkg::REG_PGAIN1: prdata = pgain1_reg;
            pmp_pkg::REG_PGAIN2: prdata = pgain2_reg;
            pmp_pkg::REG_QGAIN1: prdata = qgain1_reg;
            pmp_pkg::REG_QGAIN2: prdata = qgain2_reg;
            default:             prdata = {12'd0, ppk_reg};
        endcase
    end

    // operand selection per step
    always_comb begin
        is_div  = step_reg inside {pmp_pkg::STEP_IA, pmp_pkg::STEP_IR, pmp_pkg::STEP_PF1,
                                   pmp_pkg::STEP_PF2, pmp_pkg::STEP_FR, pmp_pkg::STEP_EA,
                                   pmp_pkg::STEP_ER};
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        case (step_reg)
            pmp_pkg::STEP_V: begin
                mul_a = {16'd0, vgain_reg};
                mul_b = ext_raw(in_data_reg[0 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_I1: begin
                mul_a = {16'd0, igain1_reg};
                mul_b = ext_raw(in_data_reg[O_I1 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_I2: begin
                mul_a = {16'd0, igain2_reg};
                mul_b = ext_raw(in_data_reg[O_I2 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_P1: begin
                mul_a = {16'd0, pgain1_reg};
                mul_b = mag_of(in_data_reg[O_P1 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_P2: begin
                mul_a = {16'd0, pgain2_reg};
                mul_b = mag_of(in_data_reg[O_P2 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_Q1: begin
                mul_a = {16'd0, qgain1_reg};
                mul_b = mag_of(in_data_reg[O_Q1 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_Q2: begin
                mul_a = {16'd0, qgain2_reg};
                mul_b = mag_of(in_data_reg[O_Q2 +: RAW_WIDTH]);
            end
            pmp_pkg::STEP_S1: begin
                mul_a = v_reg;
                mul_b = i1_reg;
            end
            pmp_pkg::STEP_S2: begin
                mul_a = v_reg;
                mul_b = i2_reg;
            end
            pmp_pkg::STEP_XA: begin
                mul_a = p2_reg;
                mul_b = {32'd0, dt_raw};
            end
            pmp_pkg::STEP_XR: begin
                mul_a = q2_reg;
                mul_b = {32'd0, dt_raw};
            end
            pmp_pkg::STEP_IA, pmp_pkg::STEP_IR: begin
                div_num = {prod_reg[61:0], 16'd0};
                div_den = pmp_pkg::MS_PER_HOUR;
            end
            pmp_pkg::STEP_PF1: begin
                div_num = {15'd0, p1_reg, 15'd0};
                div_den = s1_reg;
            end
            pmp_pkg::STEP_PF2: begin
                div_num = {15'd0, p2_reg, 15'd0};
                div_den = s2_reg;
            end
            pmp_pkg::STEP_FR: begin
                div_num = {43'd0, pmp_pkg::FREQ_NUM};
                div_den = {32'd0, fr_raw};
            end
            pmp_pkg::STEP_EA: begin
                div_num = {22'd0, in_data_reg[O_AP +: 24], 32'd0};
                div_den = {28'd0, ppk_reg};
            end
            pmp_pkg::STEP_ER: begin
                div_num = {22'd0, in_data_reg[O_RP +: 24], 32'd0};
                div_den = {28'd0, ppk_reg};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // one bit per cycle for both units, and the saturated result slices
    always_comb begin
        mul_sum   = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, mul_a_reg} : '0);
        prod_next = {mul_sum, prod_reg[MW-1:1]};
        trial     = {rem_reg, num_reg[NW-1]};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        last_iter = (cnt_reg == pmp_pkg::CNT_W'(1));
        sat8      = (prod_reg[PW-1:56] != '0) ? '1 : prod_reg[55:8];
        sat16     = (prod_reg[PW-1:64] != '0) ? '1 : prod_reg[63:16];
        pf_q      = (num_reg[NW-1:16] != '0) ? '1 : num_reg[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            vgain_reg     <= pmp_pkg::GAIN_RESET;
            igain1_reg    <= pmp_pkg::GAIN_RESET;
            igain2_reg    <= pmp_pkg::GAIN_RESET;
            pgain1_reg    <= pmp_pkg::GAIN_RESET;
            pgain2_reg    <= pmp_pkg::GAIN_RESET;
            qgain1_reg    <= pmp_pkg::GAIN_RESET;
            qgain2_reg    <= pmp_pkg::GAIN_RESET;
            ppk_reg       <= pmp_pkg::PPK_RESET;
            ea1_reg       <= '0;
            er1_reg       <= '0;
            ea2_reg       <= '0;
            er2_reg       <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    pmp_pkg::REG_VGAIN:  vgain_reg  <= pwdata;
                    pmp_pkg::REG_IGAIN1: igain1_reg <= pwdata;
                    pmp_pkg::REG_IGAIN2: igain2_reg <= pwdata;
                    pmp_pkg::REG_PGAIN1: pgain1_reg <= pwdata;
                    pmp_pkg::REG_PGAIN2: pgain2_reg <= pwdata;
                    pmp_pkg::REG_QGAIN1: qgain1_reg <= pwdata;
                    pmp_pkg::REG_QGAIN2: qgain2_reg <= pwdata;
                    default:             ppk_reg    <= pwdata[pmp_pkg::PPK_W-1:0];
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser == pmp_pkg::CMD_CLEAR) begin
                            ea1_reg       <= '0;
                            er1_reg       <= '0;
                            ea2_reg       <= '0;
                            er2_reg       <= '0;
                            have_prev_reg <= 1'b0;
                        end else begin
                            step_reg  <= pmp_pkg::STEP_V;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= is_div ? pmp_pkg::CNT_W'(NW) : pmp_pkg::CNT_W'(MW);
                    state_reg <= ST_ITER;
                end
                ST_ITER: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_iter) begin
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    if (step_reg == pmp_pkg::STEP_EA && ppk_reg != '0) begin
                        ea1_reg <= ea1_reg + num_reg[EW-1:0];
                    end
                    if (step_reg == pmp_pkg::STEP_ER) begin
                        if (ppk_reg != '0) begin
                            er1_reg <= er1_reg + num_reg[EW-1:0];
                        end
                        if (have_prev_reg && dt_raw != '0 && dt_raw < pmp_pkg::GAP_LIMIT) begin
                            ea2_reg <= ea2_reg + inca_reg;
                            er2_reg <= er2_reg + incr_reg;
                        end
                        have_prev_reg <= 1'b1;
                        state_reg     <= ST_OUT0;
                    end else begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_OUT0: begin
                    if (m_tready) begin
                        state_reg <= ST_OUT1;
                    end
                end
                ST_OUT1: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            in_data_reg <= s_tdata;
        end
        case (state_reg)
            ST_LOAD: begin
                if (is_div) begin
                    num_reg <= div_num;
                    den_reg <= div_den;
                    rem_reg <= '0;
                end else begin
                    prod_reg  <= {{MW{1'b0}}, mul_b};
                    mul_a_reg <= mul_a;
                end
            end
            ST_ITER: begin
                if (is_div) begin
                    num_reg <= {num_reg[NW-2:0], qbit};
                    rem_reg <= rem_next;
                end else begin
                    prod_reg <= prod_next;
                end
            end
            ST_WB: begin
                case (step_reg)
                    pmp_pkg::STEP_V:   v_reg    <= sat8;
                    pmp_pkg::STEP_I1:  i1_reg   <= sat8;
                    pmp_pkg::STEP_I2:  i2_reg   <= sat8;
                    pmp_pkg::STEP_P1:  p1_reg   <= sat8;
                    pmp_pkg::STEP_P2:  p2_reg   <= sat8;
                    pmp_pkg::STEP_Q1:  q1_reg   <= sat8;
                    pmp_pkg::STEP_Q2:  q2_reg   <= sat8;
                    pmp_pkg::STEP_S1:  s1_reg   <= sat16;
                    pmp_pkg::STEP_S2:  s2_reg   <= sat16;
                    pmp_pkg::STEP_IA:  inca_reg <= num_reg[EW-1:0];
                    pmp_pkg::STEP_IR:  incr_reg <= num_reg[EW-1:0];
                    pmp_pkg::STEP_PF1: pf1_reg  <= (s1_reg == '0) ? '0 : pf_q;
                    pmp_pkg::STEP_PF2: pf2_reg  <= (s2_reg == '0) ? '0 : pf_q;
                    pmp_pkg::STEP_FR:
                        f_reg <= (fr_raw == '0) ? '0 : num_reg[pmp_pkg::FREQ_W-1:0];
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign ch       = (state_reg == ST_OUT1);
    assign m_tvalid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign m_tlast  = ch;
    assign m_tuser  = ch;
    assign m_tdata  = {5'd0,
                       ch ? er2_reg : er1_reg,
                       ch ? ea2_reg : ea1_reg,
                       f_reg,
                       ch ? pf2_reg : pf1_reg,
                       ch ? s2_reg : s1_reg,
                       ch ? q2_reg : q1_reg,
                       ch ? p2_reg : p1_reg,
                       ch ? i2_reg : i1_reg,
                       v_reg};

    `ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input taken while results pending")
    `ASSERT_CLK(a_pair_order, (m_tvalid && !m_tlast && m_tready) |=> (m_tvalid && m_tlast), "channel two word missing after channel one")
    `ASSERT_CLK(a_busy_after_read, (in_acc && s_tuser != pmp_pkg::CMD_CLEAR) |=> !s_tready, "reading accepted but block not busy")
    `ASSERT_CLK(a_clear, (in_acc && s_tuser == pmp_pkg::CMD_CLEAR) |=> (ea2_reg == '0 && !have_prev_reg), "clear command left energy state")

endmodule

>>> sim/power_meter_postprocess_checker.sv
// ----------------------------------------------------------------------------
// power_meter_postprocess checker
// snoops the register port and both stream channels, predicts the channel
// one and channel two result words of every reading and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module power_meter_postprocess_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [247:0]                s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [423:0]                m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic                       channel;
        logic [pmp_pkg::VAL_W-1:0]  voltage;
        logic [pmp_pkg::VAL_W-1:0]  current;
        logic [pmp_pkg::VAL_W-1:0]  active_power;
        logic [pmp_pkg::VAL_W-1:0]  reactive_power;
        logic [pmp_pkg::VAL_W-1:0]  apparent_power;
        logic [pmp_pkg::PF_W-1:0]   power_factor;
        logic [pmp_pkg::FREQ_W-1:0] frequency;
        logic [pmp_pkg::EN_W-1:0]   active_energy;
        logic [pmp_pkg::EN_W-1:0]   reactive_energy;
        logic                       last;
    } channel_result_t;

    localparam logic [pmp_pkg::VAL_W-1:0] SAT_VAL = '1;

    logic [pmp_pkg::GAIN_W-1:0] gain_v, gain_i1, gain_i2, gain_p1, gain_p2, gain_q1, gain_q2;
    logic [pmp_pkg::PPK_W-1:0]  pulse_const;
    logic [pmp_pkg::EN_W-1:0]   energy_p1, energy_q1, energy_p2, energy_q2;
    logic                       seen_reading;

    channel_result_t result_fifo[$];

    assign pending = result_fifo.size();

    function automatic logic [23:0] magnitude24(logic [23:0] raw);
        return raw[23] ? (~raw + 24'd1) : raw;
    endfunction

    function automatic logic [pmp_pkg::VAL_W-1:0] apply_gain(logic [23:0] raw,
                                                            logic [pmp_pkg::GAIN_W-1:0] g);
        logic [63:0] prod;
        prod = ({40'd0, raw} * {32'd0, g}) >> 8;
        return (prod > {16'd0, SAT_VAL}) ? SAT_VAL : prod[pmp_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [pmp_pkg::VAL_W-1:0] volt_amp(logic [pmp_pkg::VAL_W-1:0] a,
                                                          logic [pmp_pkg::VAL_W-1:0] b);
        logic [pmp_pkg::PROD_W-1:0] prod;
        prod = ({48'd0, a} * {48'd0, b}) >> 16;
        return (prod > {48'd0, SAT_VAL}) ? SAT_VAL : prod[pmp_pkg::VAL_W-1:0];
    endfunction

    function automatic logic [pmp_pkg::PF_W-1:0] pf_ratio(logic [pmp_pkg::VAL_W-1:0] p,
                                                         logic [pmp_pkg::VAL_W-1:0] s);
        logic [63:0] q;
        if (s == 0) begin
            return '0;
        end
        q = ({16'd0, p} << 15) / {16'd0, s};
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [pmp_pkg::EN_W-1:0] energy_step(logic [pmp_pkg::VAL_W-1:0] p,
                                                            logic [15:0] dt);
        logic [127:0] x;
        x = (({80'd0, p} * {112'd0, dt}) << 16) / 128'd3600000;
        return x[63:0];
    endfunction

    function automatic logic [pmp_pkg::EN_W-1:0] pulse_step(logic [23:0] n,
                                                           logic [pmp_pkg::PPK_W-1:0] k);
        return ({40'd0, n} << 32) / {44'd0, k};
    endfunction

    task automatic predict_reading(logic [247:0] d);
        channel_result_t r1, r2;
        logic [pmp_pkg::VAL_W-1:0]  v;
        logic [pmp_pkg::FREQ_W-1:0] f;
        logic [15:0]                dt;
        v = apply_gain(d[23:0], gain_v);
        f = (d[183:168] == 0) ? '0 : pmp_pkg::FREQ_NUM / {19'd0, d[183:168]};
        if (pulse_const != 0) begin
            energy_p1 += pulse_step(d[207:184], pulse_const);
            energy_q1 += pulse_step(d[231:208], pulse_const);
        end
        r1.channel        = 1'b0;
        r1.voltage        = v;
        r1.current        = apply_gain(d[47:24], gain_i1);
        r1.active_power   = apply_gain(magnitude24(d[95:72]), gain_p1);
        r1.reactive_power = apply_gain(magnitude24(d[143:120]), gain_q1);
        r1.apparent_power = volt_amp(v, r1.current);
        r1.power_factor   = pf_ratio(r1.active_power, r1.apparent_power);
        r1.frequency      = f;
        r1.active_energy  = energy_p1;
        r1.reactive_energy = energy_q1;
        r1.last           = 1'b0;
        r2.channel        = 1'b1;
        r2.voltage        = v;
        r2.current        = apply_gain(d[71:48], gain_i2);
        r2.active_power   = apply_gain(magnitude24(d[119:96]), gain_p2);
        r2.reactive_power = apply_gain(magnitude24(d[167:144]), gain_q2);
        r2.apparent_power = volt_amp(v, r2.current);
        r2.power_factor   = pf_ratio(r2.active_power, r2.apparent_power);
        r2.frequency      = f;
        dt = d[247:232];
        if (seen_reading && dt != 0 && dt < pmp_pkg::GAP_LIMIT) begin
            energy_p2 += energy_step(r2.active_power, dt);
            energy_q2 += energy_step(r2.reactive_power, dt);
        end
        seen_reading = 1'b1;
        r2.active_energy   = energy_p2;
        r2.reactive_energy = energy_q2;
        r2.last            = 1'b1;
        result_fifo.push_back(r1);
        result_fifo.push_back(r2);
    endtask

    task automatic note_mismatch(string field, logic [63:0] exp_val, logic [63:0] got_val);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch %s: expected %h got %h", field, exp_val, got_val);
        end
    endtask

    task automatic compare_word();
        channel_result_t e;
        if (result_fifo.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("unexpected result word, channel %0d", m_tuser);
            end
            return;
        end
        e = result_fifo.pop_front();
        if (m_tuser !== e.channel)
            note_mismatch("channel", 64'(e.channel), 64'(m_tuser));
        if (m_tdata[47:0] !== e.voltage)
            note_mismatch("voltage", 64'(e.voltage), 64'(m_tdata[47:0]));
        if (m_tdata[95:48] !== e.current)
            note_mismatch("current", 64'(e.current), 64'(m_tdata[95:48]));
        if (m_tdata[143:96] !== e.active_power)
            note_mismatch("active_power", 64'(e.active_power), 64'(m_tdata[143:96]));
        if (m_tdata[191:144] !== e.reactive_power)
            note_mismatch("reactive_power", 64'(e.reactive_power), 64'(m_tdata[191:144]));
        if (m_tdata[239:192] !== e.apparent_power)
            note_mismatch("apparent_power", 64'(e.apparent_power), 64'(m_tdata[239:192]));
        if (m_tdata[255:240] !== e.power_factor)
            note_mismatch("power_factor", 64'(e.power_factor), 64'(m_tdata[255:240]));
        if (m_tdata[290:256] !== e.frequency)
            note_mismatch("frequency", 64'(e.frequency), 64'(m_tdata[290:256]));
        if (m_tdata[354:291] !== e.active_energy)
            note_mismatch("active_energy", e.active_energy, m_tdata[354:291]);
        if (m_tdata[418:355] !== e.reactive_energy)
            note_mismatch("reactive_energy", e.reactive_energy, m_tdata[418:355]);
        if (m_tlast !== e.last)
            note_mismatch("last", 64'(e.last), 64'(m_tlast));
    endtask

    initial begin
        fail_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_v       <= pmp_pkg::GAIN_RESET;
            gain_i1      <= pmp_pkg::GAIN_RESET;
            gain_i2      <= pmp_pkg::GAIN_RESET;
            gain_p1      <= pmp_pkg::GAIN_RESET;
            gain_p2      <= pmp_pkg::GAIN_RESET;
            gain_q1      <= pmp_pkg::GAIN_RESET;
            gain_q2      <= pmp_pkg::GAIN_RESET;
            pulse_const  <= pmp_pkg::PPK_RESET;
            energy_p1    = '0;
            energy_q1    = '0;
            energy_p2    = '0;
            energy_q2    = '0;
            seen_reading = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    pmp_pkg::REG_VGAIN:  gain_v      <= pwdata;
                    pmp_pkg::REG_IGAIN1: gain_i1     <= pwdata;
                    pmp_pkg::REG_IGAIN2: gain_i2     <= pwdata;
                    pmp_pkg::REG_PGAIN1: gain_p1     <= pwdata;
                    pmp_pkg::REG_PGAIN2: gain_p2     <= pwdata;
                    pmp_pkg::REG_QGAIN1: gain_q1     <= pwdata;
                    pmp_pkg::REG_QGAIN2: gain_q2     <= pwdata;
                    pmp_pkg::REG_PPK:    pulse_const <= pwdata[pmp_pkg::PPK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == pmp_pkg::CMD_CLEAR) begin
                    energy_p1    = '0;
                    energy_q1    = '0;
                    energy_p2    = '0;
                    energy_q2    = '0;
                    seen_reading = 1'b0;
                end else begin
                    predict_reading(s_tdata);
                end
            end
            if (m_tvalid && m_tready) begin
                compare_word();
            end
        end
    end

endmodule

>>> sim/power_meter_postprocess_tb.sv
// ----------------------------------------------------------------------------
// power_meter_postprocess testbench
// drives readings and clear commands through several gain settings and
// handshake pressure phases; the checker predicts and compares every word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module power_meter_postprocess_tb;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam int PHASE_WORDS    = 200;

    logic                       aclk;
    logic                       aresetn;
    logic                       psel, penable, pwrite;
    logic [pmp_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_tvalid, s_tready, s_tuser;
    logic [247:0]               s_tdata;
    logic                       m_tvalid, m_tready, m_tuser, m_tlast;
    logic [423:0]               m_tdata;
    int                         fail_count;
    int                         pending;
    int                         send_idle_pct;
    int                         recv_stall_pct;
    int                         quiet_cycles;

    power_meter_postprocess i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    power_meter_postprocess_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [23:0] pick24();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            4: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [247:0] make_reading(
        logic [23:0] v, logic [23:0] i1, logic [23:0] i2, logic [23:0] p1,
        logic [23:0] p2, logic [23:0] q1, logic [23:0] q2, logic [15:0] fr,
        logic [23:0] np, logic [23:0] nq, logic [15:0] dt);
        return {dt, nq, np, fr, q2, q1, p2, p1, i2, i1, v};
    endfunction

    function automatic logic [247:0] random_reading();
        logic [15:0] fr, dt;
        case ($urandom_range(9))
            0: fr = 16'd0;
            1: fr = 16'hFFFF;
            default: fr = 16'($urandom);
        endcase
        case ($urandom_range(19))
            0: dt = 16'd0;
            1: dt = 16'($urandom_range(10000, 65535));
            2: dt = 16'd9999;
            default: dt = 16'($urandom_range(1, 9999));
        endcase
        return make_reading(pick24(), pick24(), pick24(), pick24(), pick24(), pick24(),
                            pick24(), fr, pick24(), pick24(), dt);
    endfunction

    task automatic send_word(logic cmd, logic [247:0] d);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // a clear word leaves nothing pending and takes effect when it is accepted
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_gains(logic [31:0] g);
        write_reg(pmp_pkg::REG_VGAIN, g);
        write_reg(pmp_pkg::REG_IGAIN1, g);
        write_reg(pmp_pkg::REG_IGAIN2, g);
        write_reg(pmp_pkg::REG_PGAIN1, g);
        write_reg(pmp_pkg::REG_PGAIN2, g);
        write_reg(pmp_pkg::REG_QGAIN1, g);
        write_reg(pmp_pkg::REG_QGAIN2, g);
    endtask

    function automatic logic [31:0] random_gain();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0400_0000);
            default: return 32'h00F0_0000 + $urandom_range(32'h0020_0000);
        endcase
    endfunction

    initial begin
        int ph;
        int n;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at reset settings
        send_word(1'b0, make_reading(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
                                     16'd0, 24'h0, 24'h0, 16'd5));
        send_word(1'b0, make_reading(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h800000,
                                     24'h7FFFFF, 24'hFFFFFF, 24'h000001, 16'd1,
                                     24'hFFFFFF, 24'hFFFFFF, 16'd1));
        send_word(1'b0, make_reading(24'h123456, 24'h000100, 24'h0, 24'h7FFFFF, 24'h800000,
                                     24'h800000, 24'h7FFFFF, 16'hFFFF, 24'd3200, 24'd1,
                                     16'd9999));
        send_word(1'b0, make_reading(24'h001000, 24'h002000, 24'h003000, 24'h000800,
                                     24'hFFF000, 24'h000100, 24'hFFFFFF, 16'd10000,
                                     24'd0, 24'd7, 16'd10000));
        send_word(1'b0, make_reading(24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                     24'h7FFFFF, 24'h7FFFFF, 16'd1000, 24'd5, 24'd5,
                                     16'hFFFF));
        send_word(1'b0, make_reading(24'h000400, 24'h000400, 24'h000400, 24'h000400,
                                     24'h000400, 24'h000400, 24'h000400, 16'd10000,
                                     24'd1, 24'd1, 16'd0));
        send_word(pmp_pkg::CMD_CLEAR, '1);
        // first reading after a clear must not integrate channel two energy
        send_word(1'b0, make_reading(24'hABCDEF, 24'h00FFFF, 24'h0F0F0F, 24'h7FFFFF,
                                     24'h7FFFFF, 24'h800001, 24'h800001, 16'd9999,
                                     24'd100, 24'd200, 16'd500));
        send_word(1'b0, make_reading(24'hABCDEF, 24'h00FFFF, 24'h0F0F0F, 24'h7FFFFF,
                                     24'h7FFFFF, 24'h800001, 24'h800001, 16'd9999,
                                     24'd100, 24'd200, 16'd500));
        send_word(pmp_pkg::CMD_CLEAR, '0);
        send_word(pmp_pkg::CMD_CLEAR, '0);
        send_word(1'b0, random_reading());

        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    set_gains(32'hFFFF_FFFF);
                    write_reg(pmp_pkg::REG_PPK, 32'd1);
                end
                1: begin
                    set_gains(32'h0000_0000);
                    write_reg(pmp_pkg::REG_PPK, 32'hF_FFFF);
                end
                default: begin
                    write_reg(pmp_pkg::REG_VGAIN, random_gain());
                    write_reg(pmp_pkg::REG_IGAIN1, random_gain());
                    write_reg(pmp_pkg::REG_IGAIN2, random_gain());
                    write_reg(pmp_pkg::REG_PGAIN1, random_gain());
                    write_reg(pmp_pkg::REG_PGAIN2, random_gain());
                    write_reg(pmp_pkg::REG_QGAIN1, random_gain());
                    write_reg(pmp_pkg::REG_QGAIN2, random_gain());
                    write_reg(pmp_pkg::REG_PPK, $urandom_range(1, 32'hF_FFFF));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 3) begin
                    send_word(pmp_pkg::CMD_CLEAR, 248'({$urandom, $urandom, $urandom, $urandom,
                                                        $urandom, $urandom, $urandom,
                                                        $urandom}));
                end else begin
                    send_word(1'b0, random_reading());
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pmp_pkg.sv
rtl/core/power_meter_postprocess.sv
sim/power_meter_postprocess_checker.sv
sim/power_meter_postprocess_tb.sv
